/* design/rdhf_pkg.sv */
// rdhf_pkg: shared types, constants and codes for the ROI depth hole-fill block.
// No dependencies.
package rdhf_pkg;

	localparam int MAX_RADIUS_DEF    = 64;
	localparam int MAX_FRAME_DIM_DEF = 2048;

	localparam int PIX_W      = 16;
	localparam int SRC_W      = 3;
	localparam int CX_W       = 11;
	localparam int CY_W       = 11;
	localparam int RAD_CFG_W  = 7;
	localparam int FW_CFG_W   = 12;
	localparam int MINC_W     = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT   = 3'd4;

	localparam logic [FW_CFG_W-1:0] FRAME_WIDTH_RST = 12'd640;
	localparam logic [MINC_W-1:0]   MIN_COUNT_RST   = 13'd10;

	localparam logic [PIX_W-1:0] NO_DATA = 16'hFFFF;

	localparam logic [SRC_W-1:0] SRC_CENTRE = 3'd0;
	localparam logic [SRC_W-1:0] SRC_BOTH   = 3'd1;
	localparam logic [SRC_W-1:0] SRC_RIGHT  = 3'd2;
	localparam logic [SRC_W-1:0] SRC_LEFT   = 3'd3;
	localparam logic [SRC_W-1:0] SRC_NONE   = 3'd4;

	typedef struct packed {
		logic [PIX_W-1:0] depth_pixel;
		logic             frame_end;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] depth_out;
		logic [SRC_W-1:0] source;
	} res_t;

	typedef struct packed {
		logic acc;
		logic div_start;
		logic div_sel;
		logic lat_l;
		logic lat_r;
		logic load_out;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic rad_zero;
		logic div_done;
	} st_t;

endpackage

/* design/rdhf_div.sv */
// rdhf_div: unsigned restoring divider, one quotient bit per cycle.
// Standalone; used by rdhf_dp.
module rdhf_div #(
	parameter int NUM_W = 29,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] diff;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = ~diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

/* design/rdhf_dp.sv */
// rdhf_dp: configuration registers, pixel position, window sums, divider and result register.
// Depends on rdhf_pkg and rdhf_div.
module rdhf_dp #(
	parameter int MAX_RADIUS    = rdhf_pkg::MAX_RADIUS_DEF,
	parameter int MAX_FRAME_DIM = rdhf_pkg::MAX_FRAME_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr,
	input  logic [rdhf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rdhf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  rdhf_pkg::pix_t                      pix,
	input  rdhf_pkg::cmd_t                      cmd,
	output rdhf_pkg::st_t                       st,
	output rdhf_pkg::res_t                      res
);

	import rdhf_pkg::*;

	localparam int CNT_RAW = (2 * MAX_RADIUS + 1) * (MAX_RADIUS - 1) + 1;
	localparam int CNT_W   = (CNT_RAW > 2) ? $clog2(CNT_RAW) : 1;
	localparam int SUM_W   = CNT_W + PIX_W;
	localparam int POS_W   = $clog2(MAX_FRAME_DIM);
	localparam int DIM_W   = $clog2(MAX_FRAME_DIM + 1);
	localparam int XW      = ((DIM_W > FW_CFG_W) ? DIM_W : FW_CFG_W) + 1;
	localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
	localparam int RW      = (RAD_W > RAD_CFG_W) ? RAD_W : RAD_CFG_W;
	localparam int MW      = (CNT_W > MINC_W) ? CNT_W : MINC_W;

	logic [CX_W-1:0]      cx_q;
	logic [CY_W-1:0]      cy_q;
	logic [RAD_CFG_W-1:0] rad_q;
	logic [FW_CFG_W-1:0]  fw_q;
	logic [MINC_W-1:0]    minc_q;

	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [PIX_W-1:0] centre_q;
	logic [SUM_W-1:0] lsum_q;
	logic [SUM_W-1:0] rsum_q;
	logic [CNT_W-1:0] lcnt_q;
	logic [CNT_W-1:0] rcnt_q;
	logic [PIX_W-1:0] lavg_q;
	logic [PIX_W-1:0] ravg_q;
	res_t             res_q;

	logic [XW-1:0] fw_x, maxd_x, w_x, r_x, col_x, row_x, cx_x, cy_x, col_nx;
	logic [RW-1:0] rad_w;
	logic          in_rows, in_left, in_right, hit_centre, wrap, nz;
	logic          lq, rq;

	logic             div_done;
	logic [SUM_W-1:0] div_quot;
	logic [SUM_W-1:0] div_num;
	logic [CNT_W-1:0] div_den;

	always_comb begin
		fw_x   = XW'(fw_q);
		maxd_x = XW'(MAX_FRAME_DIM);
		w_x    = ((fw_q == '0) || (fw_x > maxd_x)) ? maxd_x : fw_x;
		rad_w  = RW'(rad_q);
		r_x    = (rad_w > RW'(MAX_RADIUS)) ? XW'(MAX_RADIUS) : XW'(rad_w);
		col_x  = XW'(col_q);
		row_x  = XW'(row_q);
		cx_x   = XW'(cx_q);
		cy_x   = XW'(cy_q);
		col_nx = col_x + XW'(1);
		wrap   = col_nx >= w_x;

		in_rows    = (row_x + r_x >= cy_x) && (row_x <= cy_x + r_x);
		in_left    = (col_x + r_x > cx_x) && (col_x < cx_x);
		in_right   = (col_x > cx_x) && (col_x < cx_x + r_x);
		hit_centre = (col_x == cx_x) && (row_x == cy_x);
		nz         = pix.depth_pixel != '0;

		lq = MW'(lcnt_q) > MW'(minc_q);
		rq = MW'(rcnt_q) > MW'(minc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			rad_q  <= '0;
			fw_q   <= FRAME_WIDTH_RST;
			minc_q <= MIN_COUNT_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_CENTER_X:    cx_q   <= cfg_data[CX_W-1:0];
				REG_CENTER_Y:    cy_q   <= cfg_data[CY_W-1:0];
				REG_RADIUS:      rad_q  <= cfg_data[RAD_CFG_W-1:0];
				REG_FRAME_WIDTH: fw_q   <= cfg_data[FW_CFG_W-1:0];
				REG_MIN_COUNT:   minc_q <= cfg_data[MINC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			centre_q <= '0;
			lsum_q   <= '0;
			rsum_q   <= '0;
			lcnt_q   <= '0;
			rcnt_q   <= '0;
		end else if (cmd.clear) begin
			centre_q <= '0;
			lsum_q   <= '0;
			rsum_q   <= '0;
			lcnt_q   <= '0;
			rcnt_q   <= '0;
		end else if (cmd.acc) begin
			if (pix.frame_end && rad_q == '0) begin
				centre_q <= '0;
				lsum_q   <= '0;
				rsum_q   <= '0;
				lcnt_q   <= '0;
				rcnt_q   <= '0;
			end else begin
				if (hit_centre)
					centre_q <= pix.depth_pixel;
				if (nz && in_rows && in_left) begin
					lsum_q <= lsum_q + SUM_W'(pix.depth_pixel);
					lcnt_q <= lcnt_q + CNT_W'(1);
				end else if (nz && in_rows && in_right) begin
					rsum_q <= rsum_q + SUM_W'(pix.depth_pixel);
					rcnt_q <= rcnt_q + CNT_W'(1);
				end
			end
			if (pix.frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= (row_q == POS_W'(MAX_FRAME_DIM - 1)) ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_nx[POS_W-1:0];
			end
		end
	end

	assign div_num = cmd.div_sel ? rsum_q : lsum_q;
	assign div_den = cmd.div_sel ? rcnt_q : lcnt_q;

	rdhf_div #(
		.NUM_W(SUM_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.lat_l)
			lavg_q <= (lcnt_q == '0) ? '0 : div_quot[PIX_W-1:0];
		if (cmd.lat_r)
			ravg_q <= (rcnt_q == '0) ? '0 : div_quot[PIX_W-1:0];
		if (cmd.load_out) begin
			if (centre_q != '0) begin
				res_q.depth_out <= centre_q;
				res_q.source    <= SRC_CENTRE;
			end else if (lq && rq) begin
				res_q.depth_out <= (ravg_q > lavg_q) ? ravg_q : lavg_q;
				res_q.source    <= SRC_BOTH;
			end else if (rq) begin
				res_q.depth_out <= ravg_q;
				res_q.source    <= SRC_RIGHT;
			end else if (lq) begin
				res_q.depth_out <= lavg_q;
				res_q.source    <= SRC_LEFT;
			end else begin
				res_q.depth_out <= NO_DATA;
				res_q.source    <= SRC_NONE;
			end
		end
	end

	assign st.frame_end = pix.frame_end;
	assign st.rad_zero  = rad_q == '0;
	assign st.div_done  = div_done;
	assign res          = res_q;

endmodule

/* design/rdhf_ctrl.sv */
// rdhf_ctrl: sequencer for pixel intake, the two side divisions and the result handoff.
// Depends on rdhf_pkg.
module rdhf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	input  logic           res_stall,
	input  rdhf_pkg::st_t  st,
	output logic           pix_stall,
	output logic           res_valid,
	output rdhf_pkg::cmd_t cmd
);

	import rdhf_pkg::*;

	localparam logic [2:0] S_ACC = 3'd0;
	localparam logic [2:0] S_DLS = 3'd1;
	localparam logic [2:0] S_DLW = 3'd2;
	localparam logic [2:0] S_DRS = 3'd3;
	localparam logic [2:0] S_DRW = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	logic [2:0] state_q, state_d;
	logic       res_valid_q;
	logic       can_load;

	assign can_load = !res_valid_q || !res_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_ACC: begin
				cmd.acc = pix_valid;
				if (pix_valid && st.frame_end && !st.rad_zero)
					state_d = S_DLS;
			end
			S_DLS: begin
				cmd.div_start = 1'b1;
				state_d       = S_DLW;
			end
			S_DLW: begin
				if (st.div_done) begin
					cmd.lat_l = 1'b1;
					state_d   = S_DRS;
				end
			end
			S_DRS: begin
				cmd.div_sel   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = S_DRW;
			end
			S_DRW: begin
				if (st.div_done) begin
					cmd.lat_r = 1'b1;
					state_d   = S_FIN;
				end
			end
			S_FIN: begin
				if (can_load) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = S_ACC;
				end
			end
			default: state_d = S_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	assign pix_stall = state_q != S_ACC;
	assign res_valid = res_valid_q;

endmodule

/* design/roi_depth_hole_fill.sv */
// roi_depth_hole_fill: ROI depth estimator with hole filling, top level.
// Depends on rdhf_pkg, rdhf_ctrl, rdhf_dp, rdhf_div.
// Throughput: one pixel per cycle within a frame.
// After a frame-end pixel with nonzero radius, input stalls while the shared divider runs
// two restoring divisions, left then right, over the sum width (29 bits at defaults); the
// result is loaded once both are done, later if the previous result is still held. Reset returns the
// registers to their defaults and clears the frame state.
module roi_depth_hole_fill #(
	parameter int MAX_RADIUS    = rdhf_pkg::MAX_RADIUS_DEF,
	parameter int MAX_FRAME_DIM = rdhf_pkg::MAX_FRAME_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  rdhf_pkg::pix_t                  pix,
	output logic                            res_valid,
	input  logic                            res_stall,
	output rdhf_pkg::res_t                  res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rdhf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rdhf_pkg::CFG_DATA_W-1:0] cfg_data
);

	import rdhf_pkg::*;

	cmd_t cmd;
	st_t  st;

	assign cfg_ready = 1'b1;

	rdhf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.res_stall(res_stall),
		.st       (st),
		.pix_stall(pix_stall),
		.res_valid(res_valid),
		.cmd      (cmd)
	);

	rdhf_dp #(
		.MAX_RADIUS   (MAX_RADIUS),
		.MAX_FRAME_DIM(MAX_FRAME_DIM)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix      (pix),
		.cmd      (cmd),
		.st       (st),
		.res      (res)
	);

endmodule

/* verif/testbench.sv */
// Self-checking testbench for roi_depth_hole_fill: streams depth frames and checks each
// frame-end depth estimate against an in-bench tracker of window sums and centre depth.
// Depends on rdhf_pkg and the roi_depth_hole_fill RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rdhf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_t pix = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	roi_depth_hole_fill dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register copies
	int cur_cx = 0;
	int cur_cy = 0;
	int cur_rad = 0;
	int cur_fw = 640;
	int cur_minc = 10;

	// frame tracker
	int pos_col = 0;
	int pos_row = 0;
	int ctr_depth = 0;
	int lsum = 0;
	int lcnt = 0;
	int rsum = 0;
	int rcnt = 0;

	pix_t stim_q [$];
	res_t depth_expected [$];
	int fail_cnt = 0;
	int src_wait = 0;
	int src_gap_max = 8;
	int snk_wait = 0;
	int snk_gap_max = 8;
	logic res_hold = 1'b0;
	bit pressure_phase = 1'b0;

	function automatic void track_pixel(input pix_t p);
		int r, w, lavg, ravg;
		bit lq, rq;
		res_t e;
		r = (cur_rad > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : cur_rad;
		w = (cur_fw == 0 || cur_fw > MAX_FRAME_DIM_DEF) ? MAX_FRAME_DIM_DEF : cur_fw;
		if (pos_col == cur_cx && pos_row == cur_cy)
			ctr_depth = p.depth_pixel;
		if (p.depth_pixel != 0 && pos_row >= cur_cy - r && pos_row <= cur_cy + r) begin
			if (cur_cx - r < pos_col && pos_col < cur_cx) begin
				lsum += p.depth_pixel;
				lcnt++;
			end else if (cur_cx < pos_col && pos_col < cur_cx + r) begin
				rsum += p.depth_pixel;
				rcnt++;
			end
		end
		pos_col++;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= MAX_FRAME_DIM_DEF)
				pos_row = 0;
		end
		if (p.frame_end) begin
			if (r != 0) begin
				lq = lcnt > cur_minc;
				rq = rcnt > cur_minc;
				lavg = (lcnt != 0) ? lsum / lcnt : 0;
				ravg = (rcnt != 0) ? rsum / rcnt : 0;
				if (ctr_depth != 0) begin
					e.depth_out = 16'(ctr_depth);
					e.source = SRC_CENTRE;
				end else if (lq && rq) begin
					e.depth_out = 16'((ravg > lavg) ? ravg : lavg);
					e.source = SRC_BOTH;
				end else if (rq) begin
					e.depth_out = 16'(ravg);
					e.source = SRC_RIGHT;
				end else if (lq) begin
					e.depth_out = 16'(lavg);
					e.source = SRC_LEFT;
				end else begin
					e.depth_out = NO_DATA;
					e.source = SRC_NONE;
				end
				depth_expected.push_back(e);
			end
			pos_col = 0;
			pos_row = 0;
			ctr_depth = 0;
			lsum = 0;
			lcnt = 0;
			rsum = 0;
			rcnt = 0;
		end
	endfunction

	// pixel driver
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			src_wait <= 0;
		end else begin
			if (pix_valid && !pix_stall)
				track_pixel(pix);
			if (!pix_valid || !pix_stall) begin
				if (src_wait != 0) begin
					src_wait <= src_wait - 1;
					pix_valid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					pix <= stim_q.pop_front();
					pix_valid <= 1'b1;
					src_wait <= $urandom_range(0, src_gap_max);
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_check
		res_t want;
		int wait_n;
		if (!arst_n) begin
			res_stall <= 1'b0;
			snk_wait <= 0;
		end else begin
			wait_n = snk_wait;
			if (res_valid && !res_stall) begin
				if (depth_expected.size() == 0) begin
					if (fail_cnt < 10)
						$display("unexpected result: depth_out=%0d source=%0d",
							res.depth_out, res.source);
					fail_cnt++;
				end else begin
					want = depth_expected.pop_front();
					if (res.depth_out !== want.depth_out || res.source !== want.source) begin
						if (fail_cnt < 10)
							$display("result differs: depth_out exp %0d got %0d, source exp %0d got %0d",
								want.depth_out, res.depth_out, want.source, res.source);
						fail_cnt++;
					end
				end
				wait_n = $urandom_range(0, snk_gap_max);
			end else if (res_valid && wait_n != 0) begin
				wait_n--;
			end
			snk_wait <= wait_n;
			res_stall <= res_hold || (wait_n != 0);
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (pressure_phase);
		@(posedge clk);
		res_hold <= 1'b1;
		repeat (800) @(posedge clk);
		res_hold <= 1'b0;
	end

	initial begin
		#20_000_000;
		$display("roi_depth_hole_fill: mismatch");
		$finish;
	end

	function automatic logic [PIX_W-1:0] rand_depth();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4)
			return '0;
		if (k == 4)
			return NO_DATA;
		return PIX_W'($urandom);
	endfunction

	function automatic void push_pix(input logic [PIX_W-1:0] d, input logic last);
		pix_t p;
		p.depth_pixel = d;
		p.frame_end = last;
		stim_q.push_back(p);
	endfunction

	task automatic wait_idle();
		int n;
		n = 0;
		@(negedge clk);
		while ((stim_q.size() != 0 || pix_valid || depth_expected.size() != 0) && n < 20000) begin
			@(negedge clk);
			n++;
		end
		repeat (100) @(posedge clk);
	endtask

	task automatic program_regs(input int cx, input int cy, input int rad, input int fw,
			input int mc);
		logic [CFG_IDX_W-1:0] idx [5];
		int v [5];
		idx = '{REG_CENTER_X, REG_CENTER_Y, REG_RADIUS, REG_FRAME_WIDTH, REG_MIN_COUNT};
		v = '{cx, cy, rad, fw, mc};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= CFG_DATA_W'(v[i]);
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_CENTER_X: cur_cx = v[i] & 'h7FF;
				REG_CENTER_Y: cur_cy = v[i] & 'h7FF;
				REG_RADIUS: cur_rad = v[i] & 'h7F;
				REG_FRAME_WIDTH: cur_fw = v[i] & 'hFFF;
				REG_MIN_COUNT: cur_minc = v[i] & 'h1FFF;
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frames(input int nframes, input int rows_max, input int cap,
			input bit tail, input int sgap, input int rgap);
		int w, npix, ntail;
		@(negedge clk);
		src_gap_max = sgap;
		snk_gap_max = rgap;
		w = (cur_fw == 0 || cur_fw > MAX_FRAME_DIM_DEF) ? MAX_FRAME_DIM_DEF : cur_fw;
		for (int f = 0; f < nframes; f++) begin
			npix = w * int'($urandom_range(1, rows_max));
			if (npix > cap)
				npix = cap;
			if ($urandom_range(0, 3) == 0)
				npix = $urandom_range(1, npix);
			if ($urandom_range(0, 7) == 0)
				npix = 1;
			for (int i = 0; i < npix; i++)
				push_pix(rand_depth(), i == npix - 1);
		end
		if (tail) begin
			ntail = $urandom_range(1, 12);
			for (int i = 0; i < ntail; i++)
				push_pix(rand_depth(), 1'b0);
		end
		wait_idle();
	endtask

	initial begin
		int w, k, rad, mc;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: radius zero, frame end gives nothing
		@(negedge clk);
		push_pix(16'd1, 1'b0);
		push_pix(NO_DATA, 1'b1);
		wait_idle();

		// three-pixel rows, centre at column 1: left is column 0, right is column 2
		program_regs(1, 0, 2, 3, 0);
		@(negedge clk);
		push_pix(NO_DATA, 1'b0); push_pix(16'h1234, 1'b0); push_pix(16'd0, 1'b1);
		push_pix(NO_DATA, 1'b0); push_pix(16'd0, 1'b0); push_pix(16'd1, 1'b1);
		push_pix(16'd4, 1'b0); push_pix(16'd0, 1'b0); push_pix(16'd4, 1'b1);
		push_pix(16'd0, 1'b0); push_pix(16'd0, 1'b0); push_pix(16'd9, 1'b1);
		push_pix(16'd5, 1'b0); push_pix(16'd0, 1'b0); push_pix(16'd0, 1'b1);
		push_pix(16'd0, 1'b0); push_pix(16'd0, 1'b0); push_pix(16'd0, 1'b1);
		wait_idle();

		// centre far outside, oversized radius, width zero, unreachable count
		program_regs(2047, 2047, 127, 0, 8191);
		@(negedge clk);
		push_pix(16'h5555, 1'b0); push_pix(16'hAAAA, 1'b0); push_pix(NO_DATA, 1'b1);
		wait_idle();

		// window hanging off the top-left corner, width above the maximum
		program_regs(0, 0, 64, 4095, 0);
		@(negedge clk);
		push_pix(16'd0, 1'b0); push_pix(16'd100, 1'b0); push_pix(16'd201, 1'b0);
		push_pix(16'd7, 1'b1);
		push_pix(16'd33, 1'b0); push_pix(16'd0, 1'b0);
		wait_idle();

		// registers change mid-frame here; the partial frame above carries on
		for (int ph = 0; ph < 16; ph++) begin
			if (ph % 5 == 4) begin
				program_regs($urandom_range(0, 8191), $urandom_range(0, 8191),
					$urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191));
				send_frames(3, 1, 50, ph % 2, (ph % 3 == 0) ? 0 : 8, (ph % 4 == 1) ? 0 : 8);
			end else begin
				w = $urandom_range(3, 16);
				k = $urandom_range(0, 9);
				rad = (k == 0) ? 0 : (k < 3) ? $urandom_range(64, 127) : $urandom_range(1, 6);
				mc = ($urandom_range(0, 9) == 0) ? 8191 : $urandom_range(0, 12);
				program_regs($urandom_range(0, w + 1), $urandom_range(0, 6), rad, w, mc);
				send_frames(3, 5, 400, $urandom_range(0, 3) == 0,
					(ph % 3 == 0) ? 0 : 8, (ph % 4 == 1) ? 0 : 8);
			end
		end

		// back-to-back short frames while the receiver holds off
		program_regs(1, 0, 2, 4, 0);
		pressure_phase = 1'b1;
		send_frames(24, 1, 4, 1'b0, 0, 0);

		if (depth_expected.size() != 0)
			$display("%0d expected results never arrived", depth_expected.size());
		if (fail_cnt == 0 && depth_expected.size() == 0)
			$display("roi_depth_hole_fill: match");
		else
			$display("roi_depth_hole_fill: mismatch");
		$finish;
	end
endmodule

/* files.f */
design/rdhf_pkg.sv
design/rdhf_div.sv
design/rdhf_dp.sv
design/rdhf_ctrl.sv
design/roi_depth_hole_fill.sv
verif/testbench.sv
